// ===== sv/assert_macros.svh =====
// Assertion helpers for the whole project. In synthesis the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold after the given sequence.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/sdge_pkg.sv =====
package sdge_pkg;

    localparam int GAIN_W = 21;
    localparam int REST_W = 17;
    localparam int NIB_W  = 4;
    localparam int DIGITS = 5;
    localparam int QUOT_W = 5;

    // The remainder modulo 100000 uses a reciprocal that is exact for every 21-bit input.
    localparam logic [REST_W-1:0] MOD_BASE   = 17'd100000;
    localparam logic [GAIN_W-1:0] MOD_RECIP  = 21'd1374390;
    localparam int                MOD_SHIFT  = 37;

    // Division by ten, exact for every value below 2**18.
    localparam logic [REST_W-1:0] DEC_RECIP  = 17'd104858;
    localparam int                DEC_SHIFT  = 20;

    localparam logic [NIB_W-1:0]  RADIX      = 4'd10;
    localparam logic [NIB_W-1:0]  ADJUST     = 4'd6;
    localparam logic [NIB_W-1:0]  LIMIT_LOW  = 4'd6;
    localparam logic [NIB_W-1:0]  LIMIT_HIGH = 4'd4;

    typedef struct packed {
        logic [NIB_W-1:0] nib;
        logic             carry;
    } t_recode;

    typedef struct packed {
        logic                         valid;
        logic [REST_W-1:0]            rest;
        logic                         carry;
        logic [DIGITS-1:0][NIB_W-1:0] nib;
    } t_dig_bus;

    function automatic t_recode recode(input logic [NIB_W-1:0] sum,
                                       input logic [NIB_W-1:0] limit);
        t_recode res;
        priority if (sum == RADIX) begin
            res.nib   = '0;
            res.carry = 1'b1;
        end else if (sum > limit) begin
            res.nib   = sum + ADJUST;
            res.carry = 1'b1;
        end else begin
            res.nib   = sum;
            res.carry = 1'b0;
        end
        return res;
    endfunction

endpackage

// ===== sv/signed_digit_gain_encoder.sv =====
// Recodes a gain given in millionths into five signed-digit nibbles, one word per
// cycle. A word is taken at every rising edge where start is high and busy is low;
// busy is high only while reset is held, so outside reset a new word may be offered in
// every cycle. Each result is shown with o_done high for exactly one cycle, once its
// word has passed through every stage, and is taken at the edge that ends it. The
// receiver cannot stall, so nothing waits and no word is turned away outside reset.
// There are two stages for the reduction modulo 100000 (a reciprocal multiply, then
// the remainder) and one stage for each of the five decimal positions, where a divide
// by ten and the carry recoding sit.
`include "assert_macros.svh"

module signed_digit_gain_encoder
    import sdge_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [GAIN_W-1:0] i_gain_micro,
    output logic              o_done,
    output logic [NIB_W-1:0]  o_nibble_hundredths,
    output logic [NIB_W-1:0]  o_nibble_thousandths,
    output logic [NIB_W-1:0]  o_nibble_e4,
    output logic [NIB_W-1:0]  o_nibble_e5,
    output logic [NIB_W-1:0]  o_nibble_millionths
);

    localparam int LATENCY = 2 + DIGITS;

    logic              accept;
    logic              mod_valid;
    logic [REST_W-1:0] mod_rest;
    t_dig_bus          bus [DIGITS+1];
    logic              low_code_ok;
    logic              high_code_ok;

    // The pipeline never stalls, so the only time a word is refused is during reset,
    // when the stage valid bits are being cleared.
    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    sdge_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_gain  (i_gain_micro),
        .o_valid (mod_valid),
        .o_rest  (mod_rest)
    );

    // The lowest position starts with no carry; the carry out of the top one is dropped.
    always_comb begin
        bus[0].valid = mod_valid;
        bus[0].rest  = mod_rest;
        bus[0].carry = 1'b0;
        bus[0].nib   = '0;
    end

    for (genvar g = 0; g < DIGITS; g++) begin : g_digit
        sdge_digit #(
            .POS (g)
        ) u_digit (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (bus[g]),
            .o_bus   (bus[g+1])
        );
    end

    assign o_done               = bus[DIGITS].valid;
    assign o_nibble_millionths  = bus[DIGITS].nib[0];
    assign o_nibble_e5          = bus[DIGITS].nib[1];
    assign o_nibble_e4          = bus[DIGITS].nib[2];
    assign o_nibble_thousandths = bus[DIGITS].nib[3];
    assign o_nibble_hundredths  = bus[DIGITS].nib[4];

    // A recoded position is either the plain digit up to its limit or a digit above the
    // limit with six added, which wraps to the top of the nibble range.
    assign low_code_ok  = (o_nibble_millionths <= LIMIT_LOW)
                          || (o_nibble_millionths > LIMIT_LOW + ADJUST);
    assign high_code_ok = (o_nibble_hundredths <= LIMIT_HIGH)
                          || (o_nibble_hundredths > LIMIT_HIGH + ADJUST);

    // Every word taken comes out exactly once, when it has passed through the whole pipeline.
    `ASSERT_IMPLIES(a_latency, i_clk, i_rst_n, accept, ##LATENCY o_done, "result missing")

    // The lowest position recodes with a limit of six: codes seven to twelve cannot occur.
    `ASSERT_ALWAYS(a_low_code, i_clk, i_rst_n, !o_done || low_code_ok, "bad lowest code")

    // The other positions recode with a limit of four: codes five to ten cannot occur (checked on the hundredths).
    `ASSERT_ALWAYS(a_high_code, i_clk, i_rst_n, !o_done || high_code_ok, "bad top code")

endmodule

// ===== sv/sdge_mod.sv =====
// Two-stage reduction of the gain modulo 100000: reciprocal quotient, then remainder.
module sdge_mod
    import sdge_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [GAIN_W-1:0] i_gain,
    output logic              o_valid,
    output logic [REST_W-1:0] o_rest
);

    localparam int PROD_W = 2 * GAIN_W;
    localparam int DIFF_W = GAIN_W + 1;

    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] n_quot;
    logic [QUOT_W-1:0] r_quot;
    logic [GAIN_W-1:0] r_gain;
    logic              r_valid_q;
    logic [DIFF_W-1:0] diff;
    logic [REST_W-1:0] n_rest;
    logic [REST_W-1:0] r_rest;
    logic              r_valid_r;

    assign prod   = PROD_W'(i_gain) * PROD_W'(MOD_RECIP);
    assign n_quot = QUOT_W'(prod >> MOD_SHIFT);

    assign diff   = DIFF_W'(r_gain) - DIFF_W'(r_quot) * DIFF_W'(MOD_BASE);
    assign n_rest = diff[REST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_q <= 1'b0;
            r_valid_r <= 1'b0;
        end else begin
            r_valid_q <= i_valid;
            r_valid_r <= r_valid_q;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_gain <= i_gain;
        r_rest <= n_rest;
    end

    assign o_valid = r_valid_r;
    assign o_rest  = r_rest;

endmodule

// ===== sv/sdge_digit.sv =====
// One pipeline stage: peels off the lowest decimal digit and recodes it with the carry.
module sdge_digit
    import sdge_pkg::*;
#(
    parameter int POS = 0
)(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dig_bus i_bus,
    output t_dig_bus o_bus
);

    localparam int               PROD_W = 2 * REST_W;
    localparam logic [NIB_W-1:0] LIMIT  = (POS == 0) ? LIMIT_LOW : LIMIT_HIGH;

    logic [PROD_W-1:0] prod;
    logic [REST_W-1:0] quot;
    logic [REST_W-1:0] diff;
    logic [NIB_W-1:0]  sum;
    t_recode           rc;
    t_dig_bus          n_bus;
    t_dig_bus          r_bus;

    assign prod = PROD_W'(i_bus.rest) * PROD_W'(DEC_RECIP);
    assign quot = REST_W'(prod >> DEC_SHIFT);
    assign diff = i_bus.rest - ((quot << 3) + (quot << 1));
    assign sum  = diff[NIB_W-1:0] + NIB_W'(i_bus.carry);
    assign rc   = recode(sum, LIMIT);

    always_comb begin
        n_bus          = i_bus;
        n_bus.rest     = quot;
        n_bus.carry    = rc.carry;
        n_bus.nib[POS] = rc.nib;
    end

    // Only the valid bit is cleared by reset; the data simply follows it.
    always_ff @(posedge i_clk) begin
        r_bus.rest  <= n_bus.rest;
        r_bus.carry <= n_bus.carry;
        r_bus.nib   <= n_bus.nib;
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else begin
            r_bus.valid <= n_bus.valid;
        end
    end

    assign o_bus = r_bus;

endmodule

// ===== test/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sdge_pkg::*;

    // Only the five lowest decimal digits of the gain take part in the coding.
    localparam int unsigned GAIN_WRAP      = 100000;
    localparam int unsigned DECIMAL_RADIX  = 10;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned DRAIN_CYCLES   = 12;
    localparam int unsigned REPORT_LIMIT   = 10;

    // The five coded positions of one result, most significant weight first.
    typedef struct packed {
        logic [NIB_W-1:0] hundredths;
        logic [NIB_W-1:0] thousandths;
        logic [NIB_W-1:0] e4;
        logic [NIB_W-1:0] e5;
        logic [NIB_W-1:0] millionths;
    } t_nibble_set;

    // A coding still owed by the block, kept with the gain that caused it for reporting.
    typedef struct {
        logic [GAIN_W-1:0] gain;
        t_nibble_set       nibbles;
    } t_owed_coding;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [GAIN_W-1:0] i_gain_micro;
    logic              o_done;
    logic [NIB_W-1:0]  o_nibble_hundredths;
    logic [NIB_W-1:0]  o_nibble_thousandths;
    logic [NIB_W-1:0]  o_nibble_e4;
    logic [NIB_W-1:0]  o_nibble_e5;
    logic [NIB_W-1:0]  o_nibble_millionths;

    t_owed_coding owed_codings[$];
    int unsigned  words_sent;
    int unsigned  codings_checked;
    int unsigned  mismatch_count;
    int unsigned  quiet_cycles;
    bit           gaps_on;

    signed_digit_gain_encoder u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_gain_micro         (i_gain_micro),
        .o_done               (o_done),
        .o_nibble_hundredths  (o_nibble_hundredths),
        .o_nibble_thousandths (o_nibble_thousandths),
        .o_nibble_e4          (o_nibble_e4),
        .o_nibble_e5          (o_nibble_e5),
        .o_nibble_millionths  (o_nibble_millionths)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Signed-digit coding of one gain. The digits are walked from the millionths
    // upward with a carry. A position that reaches exactly ten is written as zero
    // and passes the carry on; otherwise a position above its ceiling (six for the
    // lowest, four for the rest) has six added, which in four bits is the digit
    // minus ten, and also passes a carry on. Whatever leaves the top is lost.
    function automatic t_nibble_set predict_coding(input logic [GAIN_W-1:0] gain);
        logic [NIB_W-1:0] coded [DIGITS];
        int unsigned      rest;
        int unsigned      sum;
        int unsigned      carry;
        int unsigned      ceiling;
        t_nibble_set      res;
        rest  = gain % GAIN_WRAP;
        carry = 0;
        for (int pos = 0; pos < DIGITS; pos++) begin
            sum     = rest % DECIMAL_RADIX + carry;
            rest    = rest / DECIMAL_RADIX;
            ceiling = (pos == 0) ? 32'(LIMIT_LOW) : 32'(LIMIT_HIGH);
            if (sum == DECIMAL_RADIX) begin
                coded[pos] = '0;
                carry      = 1;
            end else if (sum > ceiling) begin
                coded[pos] = NIB_W'(sum + ADJUST);
                carry      = 1;
            end else begin
                coded[pos] = NIB_W'(sum);
                carry      = 0;
            end
        end
        res.millionths  = coded[0];
        res.e5          = coded[1];
        res.e4          = coded[2];
        res.thousandths = coded[3];
        res.hundredths  = coded[4];
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    task automatic compare_nibble(input string name, input logic [GAIN_W-1:0] gain,
                                  input logic [NIB_W-1:0] want,
                                  input logic [NIB_W-1:0] got);
        if (got !== want) begin
            report_mismatch($sformatf("gain %0d, %s expected %0d, got %0d",
                                      gain, name, want, got));
        end
    endtask

    // Offers one word and holds it until the block takes it. With gaps switched on,
    // start is dropped for a few cycles beforehand now and then, with junk on the
    // data lines. Start is never lowered and raised again at the same falling edge:
    // a word that follows straight on simply overwrites the data.
    task automatic send_gain(input logic [GAIN_W-1:0] gain);
        int unsigned gap;
        if (gaps_on && $urandom_range(99) < 8) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge i_clk);
                start        <= 1'b0;
                i_gain_micro <= GAIN_W'($urandom);
            end
        end
        @(negedge i_clk);
        start        <= 1'b1;
        i_gain_micro <= gain;
        do begin
            @(posedge i_clk);
        end while (busy);
        words_sent++;
        owed_codings.push_back('{gain: gain, nibbles: predict_coding(gain)});
    endtask

    // A gain whose low digits cluster round the coding thresholds (four, five,
    // six, seven and nine), so that carries chain and reach ten often, with a
    // random multiple of 100000 on top.
    function automatic logic [GAIN_W-1:0] threshold_rich_gain();
        int unsigned value;
        int unsigned digit;
        value = 0;
        for (int i = 0; i < DIGITS; i++) begin
            case ($urandom_range(7))
                0:       digit = 4;
                1:       digit = 5;
                2:       digit = 6;
                3:       digit = 7;
                4:       digit = 9;
                5:       digit = 0;
                default: digit = $urandom_range(9);
            endcase
            value = value * DECIMAL_RADIX + digit;
        end
        value += GAIN_WRAP * $urandom_range(19);
        return GAIN_W'(value);
    endfunction

    function automatic logic [GAIN_W-1:0] random_gain();
        case ($urandom_range(3))
            0:       return GAIN_W'($urandom);
            1:       return GAIN_W'($urandom_range(1999999));
            default: return threshold_rich_gain();
        endcase
    endfunction

    // The bounds of the stated range, the all-ones word above it, and alternating
    // bit patterns so that every input bit is seen at both levels early on.
    task automatic test_range_extremes();
        send_gain(21'd0);
        send_gain(21'd1);
        send_gain(21'd99999);
        send_gain(21'd100000);
        send_gain(21'd1999999);
        send_gain({GAIN_W{1'b1}});
        send_gain(21'h0AAAAA);
        send_gain(21'h155555);
    endtask

    // Each position exactly at its ceiling and one above it, with and without an
    // incoming carry.
    task automatic test_digit_thresholds();
        send_gain(21'd6);
        send_gain(21'd7);
        send_gain(21'd44444);
        send_gain(21'd55555);
        send_gain(21'd46);
        send_gain(21'd47);
        send_gain(21'd45456);
    endtask

    // A position reaching ten through the carry, a carry rippling through every
    // position, and a carry leaving the hundredths that must simply be lost.
    task automatic test_carry_cases();
        send_gain(21'd97);
        send_gain(21'd1099999);
        send_gain(21'd90000);
        send_gain(21'd49997);
        send_gain(21'd1594947);
    endtask

    // A long run with start held high throughout, one word per cycle.
    task automatic test_back_to_back(input int unsigned count);
        gaps_on = 1'b0;
        repeat (count) send_gain(random_gain());
    endtask

    // The bulk of the random words, with start dropped now and then.
    task automatic test_random_gaps(input int unsigned count);
        gaps_on = 1'b1;
        repeat (count) send_gain(random_gain());
    endtask

    // Every strobed result is held against the oldest coding still owed.
    always @(posedge i_clk) begin : result_check
        t_owed_coding owed;
        if (i_rst_n && o_done) begin
            if (owed_codings.size() == 0) begin
                report_mismatch("result strobed with no word outstanding");
            end else begin
                owed = owed_codings.pop_front();
                codings_checked++;
                compare_nibble("hundredths", owed.gain, owed.nibbles.hundredths,
                               o_nibble_hundredths);
                compare_nibble("thousandths", owed.gain, owed.nibbles.thousandths,
                               o_nibble_thousandths);
                compare_nibble("e4", owed.gain, owed.nibbles.e4, o_nibble_e4);
                compare_nibble("e5", owed.gain, owed.nibbles.e5, o_nibble_e5);
                compare_nibble("millionths", owed.gain, owed.nibbles.millionths,
                               o_nibble_millionths);
            end
        end
    end

    // The run is abandoned if neither a word nor a result moves for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d codings still owed.", owed_codings.size());
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_gain_micro    = '0;
        words_sent      = 0;
        codings_checked = 0;
        mismatch_count  = 0;
        quiet_cycles    = 0;
        gaps_on         = 1'b0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_range_extremes();
        test_digit_thresholds();
        test_carry_cases();
        test_back_to_back(150);
        test_random_gaps(350);

        // Lower start before anything else can be taken, then let the pipe empty.
        @(negedge i_clk);
        start <= 1'b0;
        while (owed_codings.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d gain words (range ends, digit thresholds, carry chains, random).",
                 words_sent);
        $display("Checked %0d codings, with and without idle gaps; %0d mismatches.",
                 codings_checked, mismatch_count);
        if (mismatch_count == 0 && owed_codings.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/sdge_pkg.sv
sv/sdge_mod.sv
sv/sdge_digit.sv
sv/signed_digit_gain_encoder.sv
test/tb.sv
